[rtl/triangle_unit_normal_core_assert.svh]
// assertion macros for the triangle unit normal checker
// used by triangle_unit_normal_core_chk only
`ifndef TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`define TUN_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define TUN_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

[rtl/tun_pkg.sv]
// types and widths for the triangle unit normal core
// no dependencies
package tun_pkg;
  localparam int COORD_WIDTH = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH = OUT_FRAC_BITS + 2;
  localparam int EDGE_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * EDGE_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int MAG_WIDTH = PROD_WIDTH;
  localparam int SQ_WIDTH = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH = SQ_WIDTH + 2;
  localparam int ROOT_WIDTH = SUM_WIDTH / 2;
  localparam int NUM_WIDTH = MAG_WIDTH + OUT_FRAC_BITS;
  localparam int QUO_WIDTH = OUT_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] nx, ny, nz;
    logic degenerate;
  } out_item_t;
endpackage

[rtl/tun_sqrt_div.sv]
// pipelined floor square root and three restoring dividers
// depends on tun_pkg
module tun_sqrt_div (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [tun_pkg::SUM_WIDTH-1:0] sum,
  input  logic [tun_pkg::MAG_WIDTH-1:0] mag [3],
  input  logic [2:0] neg,
  output logic out_valid,
  output tun_pkg::out_item_t result
);
  localparam int RW = tun_pkg::ROOT_WIDTH;
  localparam int SW = tun_pkg::SUM_WIDTH;
  localparam int NW = tun_pkg::NUM_WIDTH;
  localparam int QW = tun_pkg::QUO_WIDTH;
  localparam int MW = tun_pkg::MAG_WIDTH;

  // square root: one result bit per stage, remainder method
  logic          sv   [RW+1];
  logic [SW-1:0] srem [RW+1];
  logic [SW-1:0] sval [RW+1];
  logic [RW-1:0] sroot[RW+1];
  logic [MW-1:0] smag [RW+1][3];
  logic [2:0]    sneg [RW+1];
  logic          szero[RW+1];

  always_comb begin
    sv[0] = in_valid;
    srem[0] = '0;
    sval[0] = sum;
    sroot[0] = '0;
    smag[0] = mag;
    sneg[0] = neg;
    szero[0] = (sum == '0);
  end

  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    logic [SW-1:0] r2, trial;
    always_comb begin
      r2 = {srem[s][SW-3:0], sval[s][SW-1:SW-2]};
      trial = {{(SW-RW-2){1'b0}}, sroot[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else sv[s+1] <= sv[s];
      if (r2 >= trial) begin
        srem[s+1] <= r2 - trial;
        sroot[s+1] <= {sroot[s][RW-2:0], 1'b1};
      end else begin
        srem[s+1] <= r2;
        sroot[s+1] <= {sroot[s][RW-2:0], 1'b0};
      end
      sval[s+1] <= {sval[s][SW-3:0], 2'b00};
      smag[s+1] <= smag[s];
      sneg[s+1] <= sneg[s];
      szero[s+1] <= szero[s];
    end
  end

  // division: one quotient bit per stage per lane
  logic          dv   [QW+1];
  logic [NW-1:0] drem [QW+1][3];
  logic [QW-1:0] dq   [QW+1][3];
  logic [RW-1:0] droot[QW+1];
  logic [2:0]    dneg [QW+1];
  logic          dzero[QW+1];

  always_comb begin
    dv[0] = sv[RW];
    droot[0] = sroot[RW];
    dneg[0] = sneg[RW];
    dzero[0] = szero[RW];
    for (int k = 0; k < 3; k++) begin
      drem[0][k] = {smag[RW][k], {tun_pkg::OUT_FRAC_BITS{1'b0}}};
      dq[0][k] = '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int B = QW - 1 - s;
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [NW+QW-1:0] dsh;
      always_comb dsh = {{(NW+QW-RW){1'b0}}, droot[s]} << B;
      always_ff @(posedge clk) begin
        if ({{QW{1'b0}}, drem[s][k]} >= dsh) begin
          drem[s+1][k] <= drem[s][k] - dsh[NW-1:0];
          dq[s+1][k] <= dq[s][k] | (QW'(1) << B);
        end else begin
          drem[s+1][k] <= drem[s][k];
          dq[s+1][k] <= dq[s][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else dv[s+1] <= dv[s];
      droot[s+1] <= droot[s];
      dneg[s+1] <= dneg[s];
      dzero[s+1] <= dzero[s];
    end
  end

  logic [tun_pkg::OUT_WIDTH-1:0] o [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o[k] = {1'b0, dq[QW][k]};
      if (dneg[QW][k]) o[k] = -o[k];
      if (dzero[QW]) o[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv[QW];
    result.nx <= o[0];
    result.ny <= o[1];
    result.nz <= o[2];
    result.degenerate <= dzero[QW];
  end
endmodule

[rtl/triangle_unit_normal_core.sv]
// triangle unit normal core: edges, cross product, squares, root, divide
// depends on tun_pkg and tun_sqrt_div
// One item per cycle when start is high; busy is always low. Each result
// appears on result with done high for one cycle, after the edge, product,
// magnitude and square registers, one root stage per root bit, one divider
// stage per quotient bit and the output register. The receiver cannot stall.
module triangle_unit_normal_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  tun_pkg::in_item_t item,
  output logic done,
  output tun_pkg::out_item_t result
);
  localparam int EW = tun_pkg::EDGE_WIDTH;
  localparam int PW = tun_pkg::PROD_WIDTH;
  localparam int CW = tun_pkg::CROSS_WIDTH;
  localparam int MW = tun_pkg::MAG_WIDTH;
  localparam int QW = tun_pkg::SQ_WIDTH;

  assign busy = 1'b0;

  logic v1, v2, v3, v4;
  logic signed [EW-1:0] e1 [3], e2 [3];
  logic signed [PW-1:0] p [6];
  logic signed [CW-1:0] n [3];
  logic [MW-1:0] m3 [3], m4 [3];
  logic [2:0] ng3, ng4;
  logic [QW-1:0] sq [3];
  logic [tun_pkg::SUM_WIDTH-1:0] sum4;

  always_comb begin
    for (int k = 0; k < 3; k++) n[k] = CW'(p[2*k]) - CW'(p[2*k+1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v1 <= start; v2 <= v1; v3 <= v2; v4 <= v3;
    end
    e1[0] <= EW'(item.bx) - EW'(item.ax);
    e1[1] <= EW'(item.by) - EW'(item.ay);
    e1[2] <= EW'(item.bz) - EW'(item.az);
    e2[0] <= EW'(item.cx) - EW'(item.ax);
    e2[1] <= EW'(item.cy) - EW'(item.ay);
    e2[2] <= EW'(item.cz) - EW'(item.az);
    for (int k = 0; k < 3; k++) begin
      p[2*k]   <= PW'(e1[(k+1)%3]) * PW'(e2[(k+2)%3]);
      p[2*k+1] <= PW'(e1[(k+2)%3]) * PW'(e2[(k+1)%3]);
    end
    for (int k = 0; k < 3; k++) begin
      ng3[k] <= n[k][CW-1];
      m3[k] <= n[k][CW-1] ? MW'(-n[k]) : MW'(n[k]);
    end
    for (int k = 0; k < 3; k++) sq[k] <= m3[k] * m3[k];
    m4 <= m3;
    ng4 <= ng3;
  end

  always_comb sum4 = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

  tun_sqrt_div u_sqrt_div (
    .clk(clk), .rst(rst), .in_valid(v4), .sum(sum4), .mag(m4), .neg(ng4),
    .out_valid(done), .result(result)
  );
endmodule

[rtl/triangle_unit_normal_core_chk.sv]
// port checker for triangle_unit_normal_core, bound to the top level
// depends on tun_pkg and triangle_unit_normal_core_assert.svh
`include "triangle_unit_normal_core_assert.svh"
module triangle_unit_normal_core_chk (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input tun_pkg::out_item_t result
);
  `TUN_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
  `TUN_ASSERT_IMPL(a_degen_zero, done && result.degenerate,
    result.nx == '0 && result.ny == '0 && result.nz == '0)
  `TUN_ASSERT_IMPL(a_nx_range, done,
    $signed(result.nx) <= 16384 && $signed(result.nx) >= -16384)
  `TUN_ASSERT_NEXT(a_reset_quiet, rst, !done)
endmodule

bind triangle_unit_normal_core triangle_unit_normal_core_chk u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result)
);

[sim/tb.sv]
// testbench for triangle_unit_normal_core: directed table then random triangles
// depends on tun_pkg and the core rtl; predicts each normal not given in the table and compares in order
`timescale 1ns / 100ps

module tb;
  localparam int LATENCY = 4 + 35 + 15 + 1;
  localparam int N_RANDOM = 1430;
  localparam int IN_BITS = $bits(tun_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tun_pkg::in_item_t item = '0;
  logic done;
  tun_pkg::out_item_t result;

  tun_pkg::out_item_t normal_q[$];
  int errors = 0;

  typedef struct {
    tun_pkg::in_item_t pts;
    bit known;
    tun_pkg::out_item_t want;
  } row_t;

  row_t rows[$];

  triangle_unit_normal_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [95:0] isqrt(logic [95:0] s);
    logic [95:0] r;
    logic [95:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (96'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic tun_pkg::out_item_t predict_normal(tun_pkg::in_item_t p);
    tun_pkg::out_item_t o;
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] n[3];
    logic [95:0] sum;
    logic [95:0] root;
    logic [95:0] num;
    logic [95:0] q;
    logic [63:0] m;
    logic [tun_pkg::OUT_WIDTH-1:0] v[3];
    e1[0] = 64'(p.bx) - 64'(p.ax);
    e1[1] = 64'(p.by) - 64'(p.ay);
    e1[2] = 64'(p.bz) - 64'(p.az);
    e2[0] = 64'(p.cx) - 64'(p.ax);
    e2[1] = 64'(p.cy) - 64'(p.ay);
    e2[2] = 64'(p.cz) - 64'(p.az);
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      n[k] = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
      m = n[k] < 0 ? -n[k] : n[k];
      sum += 96'(m) * 96'(m);
    end
    o = '0;
    if (sum == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    root = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      m = n[k] < 0 ? -n[k] : n[k];
      num = 96'(m) << tun_pkg::OUT_FRAC_BITS;
      q = num / root;
      v[k] = n[k] < 0 ? -q[tun_pkg::OUT_WIDTH-1:0] : q[tun_pkg::OUT_WIDTH-1:0];
    end
    o.nx = v[0];
    o.ny = v[1];
    o.nz = v[2];
    return o;
  endfunction

  function automatic tun_pkg::in_item_t rand_tri(int mode);
    tun_pkg::in_item_t p;
    p = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode == 1) begin
      // small triangle near a random point
      p.bx = p.ax + 16'($signed($urandom_range(0, 15)) - 8);
      p.by = p.ay + 16'($signed($urandom_range(0, 15)) - 8);
      p.bz = p.az + 16'($signed($urandom_range(0, 15)) - 8);
      p.cx = p.ax + 16'($signed($urandom_range(0, 15)) - 8);
      p.cy = p.ay + 16'($signed($urandom_range(0, 15)) - 8);
      p.cz = p.az + 16'($signed($urandom_range(0, 15)) - 8);
    end else if (mode == 2) begin
      // collinear: c = a + 2*(b - a) in small steps
      p.bx = p.ax + 16'($urandom_range(0, 255));
      p.by = p.ay + 16'($urandom_range(0, 255));
      p.bz = p.az + 16'($urandom_range(0, 255));
      p.cx = p.ax + 16'(2 * (p.bx - p.ax));
      p.cy = p.ay + 16'(2 * (p.by - p.ay));
      p.cz = p.az + 16'(2 * (p.bz - p.az));
    end else if (mode == 3) begin
      // axis-aligned triangle
      p.az = p.ax;
      p.bz = p.ax;
      p.cz = p.ax;
    end
    return p;
  endfunction

  task automatic add_row(tun_pkg::in_item_t p, bit known, tun_pkg::out_item_t want);
    row_t r;
    r.pts = p;
    r.known = known;
    r.want = want;
    rows.push_back(r);
  endtask

  task automatic send_item(tun_pkg::in_item_t p, tun_pkg::out_item_t want);
    start <= 1'b1;
    item <= p;
    normal_q.push_back(want);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (normal_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        tun_pkg::out_item_t w;
        w = normal_q.pop_front();
        if (result.nx !== w.nx) begin
          $error("nx expected %0d got %0d", w.nx, result.nx);
          errors++;
        end
        if (result.ny !== w.ny) begin
          $error("ny expected %0d got %0d", w.ny, result.ny);
          errors++;
        end
        if (result.nz !== w.nz) begin
          $error("nz expected %0d got %0d", w.nz, result.nz);
          errors++;
        end
        if (result.degenerate !== w.degenerate) begin
          $error("degenerate expected %0d got %0d", w.degenerate, result.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    tun_pkg::in_item_t p;
    tun_pkg::out_item_t z;
    tun_pkg::out_item_t up;
    bit quiet;
    z = '0;
    z.degenerate = 1'b1;
    up = '0;
    up.nz = 16'sd16384;

    add_row('0, 1, z);
    add_row('1, 1, z);
    p = '0;
    p.bx = 16'sd4096;
    p.cy = 16'sd4096;
    add_row(p, 1, up);
    p.cx = 16'sd4096;
    p.cy = 16'sd0;
    p.by = 16'sd4096;
    p.bx = 16'sd0;
    add_row(p, 1, '{nx: 0, ny: 0, nz: -16'sd16384, degenerate: 0});
    p = '0;
    p.by = 16'sd1;
    p.cz = 16'sd1;
    add_row(p, 1, '{nx: 16'sd16384, ny: 0, nz: 0, degenerate: 0});
    p = '0;
    p.ax = -16'sd32768; p.ay = -16'sd32768; p.az = -16'sd32768;
    p.bx = 16'sd32767; p.by = -16'sd32768; p.bz = -16'sd32768;
    p.cx = -16'sd32768; p.cy = 16'sd32767; p.cz = -16'sd32768;
    add_row(p, 1, up);
    p.cz = 16'sd32767;
    add_row(p, 0, '0);
    p = {9{16'h7fff}};
    p.bx = -16'sd32768;
    p.cy = -16'sd32768;
    p.cz = -16'sd32768;
    add_row(p, 0, '0);
    p = {9{16'h8000}};
    p.ax = 16'sd32767;
    p.by = 16'sd32767;
    p.cz = 16'sd32767;
    add_row(p, 0, '0);
    p = '0;
    p.bx = 16'sd3; p.by = 16'sd3; p.bz = 16'sd3;
    p.cx = 16'sd7; p.cy = 16'sd7; p.cz = 16'sd7;
    add_row(p, 1, z);
    for (int i = 0; i < 10; i++) add_row(rand_tri(i % 4), 0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].pts, rows[i].known ? rows[i].want : predict_normal(rows[i].pts));
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = i >= 500 && i < 800;
      if (!quiet && $urandom_range(0, 99) < 27) begin
        start <= 1'b0;
        item <= IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      p = rand_tri($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
      send_item(p, predict_normal(p));
    end
    start <= 1'b0;

    while (normal_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
